// ----- hw/rtl/rtlex_pkg.sv -----
// shared types and constants of the resource text lexer
`default_nettype none
package rtlex_pkg;

  // result event codes
  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  // token class codes
  localparam logic [1:0] CLS_OP   = 2'd0;
  localparam logic [1:0] CLS_WORD = 2'd1;
  localparam logic [1:0] CLS_STR  = 2'd2;

  // characters the lexer reacts to
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // result group queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int MAX_RES = 4;

  // one result record
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] data;
    logic [1:0] cls;
  } res_t;

  // all results caused by one input item
  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   rec;
  } grp_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rtlex_front.sv -----
// lexer front: accepts text bytes, runs the mode machine, builds result groups
`default_nettype none
module rtlex_front #(
  parameter int LINE_BITS = 24
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  wire                    action,
  input  wire  [7:0]             data_byte,
  input  rtlex_pkg::q_stat_t     stat,
  output logic                   push,
  output rtlex_pkg::grp_t        wr_grp,
  output logic [LINE_BITS-1:0]   wr_line
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_WORD = 3'd1;
  localparam logic [2:0] M_STR  = 3'd2;
  localparam logic [2:0] M_STRQ = 3'd3;
  localparam logic [2:0] M_REM  = 3'd4;

  logic [2:0]           mode, mode_next;
  logic                 slash, slash_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic                 accept;
  logic [2:0]           n;
  logic                 run, go_idle;

  function automatic logic is_op(input logic [7:0] c);
    is_op = (c == rtlex_pkg::CH_COMMA) || (c == rtlex_pkg::CH_EQ) ||
            (c == rtlex_pkg::CH_LPAR) || (c == rtlex_pkg::CH_RPAR) ||
            (c == rtlex_pkg::CH_SEMI) || (c == rtlex_pkg::CH_LBRACE) ||
            (c == rtlex_pkg::CH_RBRACE);
  endfunction

  function automatic logic is_sp(input logic [7:0] c);
    is_sp = (c == rtlex_pkg::CH_SPACE) || (c == rtlex_pkg::CH_TAB) ||
            (c == rtlex_pkg::CH_CR) || (c == rtlex_pkg::CH_LF);
  endfunction

  assign item_stall = stat.full;
  assign accept     = item_valid && !item_stall;

  // classify one byte against the current mode and collect its results
  always_comb begin
    mode_next       = mode;
    slash_next      = slash;
    line_count_next = line_count;
    n               = 3'd0;
    run             = 1'b0;
    go_idle         = 1'b0;
    wr_grp          = '0;
    if (mode_next > M_REM) begin
      mode_next = M_IDLE;
    end
    if (action) begin
      // end of input: flush open token or flag an open string, then back to the start of a text
      if (slash) begin
        wr_grp.rec[0] = '{ev: rtlex_pkg::EV_BYTE, data: rtlex_pkg::CH_SLASH,
                          cls: rtlex_pkg::CLS_WORD};
        wr_grp.rec[1] = '{ev: rtlex_pkg::EV_END, data: 8'd0, cls: rtlex_pkg::CLS_WORD};
        n = 3'd2;
      end else if (mode_next == M_WORD) begin
        wr_grp.rec[0] = '{ev: rtlex_pkg::EV_END, data: 8'd0, cls: rtlex_pkg::CLS_WORD};
        n = 3'd1;
      end else if (mode_next == M_STRQ) begin
        wr_grp.rec[0] = '{ev: rtlex_pkg::EV_END, data: 8'd0, cls: rtlex_pkg::CLS_STR};
        n = 3'd1;
      end else if (mode_next == M_STR) begin
        wr_grp.rec[0] = '{ev: rtlex_pkg::EV_ERR, data: 8'd0, cls: rtlex_pkg::CLS_STR};
        n = 3'd1;
      end
      mode_next       = M_IDLE;
      slash_next      = 1'b0;
      line_count_next = LINE_BITS'(1);
    end else if (slash) begin
      // resolve the held slash with its lookahead byte
      slash_next = 1'b0;
      if (data_byte == rtlex_pkg::CH_SLASH) begin
        if (mode_next == M_WORD) begin
          wr_grp.rec[0] = '{ev: rtlex_pkg::EV_END, data: 8'd0, cls: rtlex_pkg::CLS_WORD};
          n = 3'd1;
        end
        mode_next = M_REM;
      end else begin
        wr_grp.rec[0] = '{ev: rtlex_pkg::EV_BYTE, data: rtlex_pkg::CH_SLASH,
                          cls: rtlex_pkg::CLS_WORD};
        n         = 3'd1;
        mode_next = M_WORD;
        run       = 1'b1;
      end
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (mode_next)
        M_STR: begin
          if (data_byte == rtlex_pkg::CH_QUOTE) begin
            mode_next = M_STRQ;
          end else begin
            wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_BYTE, data: data_byte,
                                   cls: rtlex_pkg::CLS_STR};
            n = n + 3'd1;
          end
        end
        M_STRQ: begin
          if (data_byte == rtlex_pkg::CH_QUOTE) begin
            wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_BYTE, data: data_byte,
                                   cls: rtlex_pkg::CLS_STR};
            n         = n + 3'd1;
            mode_next = M_STR;
          end else begin
            wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_END, data: 8'd0,
                                   cls: rtlex_pkg::CLS_STR};
            n         = n + 3'd1;
            mode_next = M_IDLE;
            go_idle   = 1'b1;
          end
        end
        M_REM: begin
          if (data_byte == rtlex_pkg::CH_LF) begin
            if (line_count_next != '1) begin
              line_count_next = line_count_next + LINE_BITS'(1);
            end
            mode_next = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_sp(data_byte) || is_op(data_byte) || data_byte == rtlex_pkg::CH_HASH) begin
            wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_END, data: 8'd0,
                                   cls: rtlex_pkg::CLS_WORD};
            n         = n + 3'd1;
            mode_next = M_IDLE;
            go_idle   = 1'b1;
          end else if (data_byte == rtlex_pkg::CH_SLASH) begin
            slash_next = 1'b1;
          end else begin
            wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_BYTE, data: data_byte,
                                   cls: rtlex_pkg::CLS_WORD};
            n = n + 3'd1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          go_idle   = 1'b1;
        end
      endcase

      // handling between tokens
      if (go_idle) begin
        if (is_sp(data_byte)) begin
          if (data_byte == rtlex_pkg::CH_LF && line_count_next != '1) begin
            line_count_next = line_count_next + LINE_BITS'(1);
          end
        end else if (is_op(data_byte)) begin
          wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_BYTE, data: data_byte,
                                 cls: rtlex_pkg::CLS_OP};
          n = n + 3'd1;
          wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_END, data: 8'd0,
                                 cls: rtlex_pkg::CLS_OP};
          n = n + 3'd1;
        end else if (data_byte == rtlex_pkg::CH_HASH) begin
          mode_next = M_REM;
        end else if (data_byte == rtlex_pkg::CH_SLASH) begin
          slash_next = 1'b1;
        end else if (data_byte == rtlex_pkg::CH_QUOTE) begin
          mode_next = M_STR;
        end else begin
          wr_grp.rec[n[1:0]] = '{ev: rtlex_pkg::EV_BYTE, data: data_byte,
                                 cls: rtlex_pkg::CLS_WORD};
          n         = n + 3'd1;
          mode_next = M_WORD;
        end
      end
    end
    wr_grp.cnt = n;
  end

  // all results of one byte carry the line count seen when it arrived
  assign wr_line = line_count;
  assign push    = accept && (n != 3'd0);

  // mode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      slash      <= 1'b0;
      line_count <= LINE_BITS'(1);
    end else if (accept) begin
      mode       <= mode_next;
      slash      <= slash_next;
      line_count <= line_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rtlex_fifo.sv -----
// short queue of result groups between lexer front and back
`default_nettype none
module rtlex_fifo #(
  parameter int LINE_BITS = 24
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  rtlex_pkg::grp_t        wr_grp,
  input  wire  [LINE_BITS-1:0]   wr_line,
  input  wire                    pop,
  output rtlex_pkg::grp_t        rd_grp,
  output logic [LINE_BITS-1:0]   rd_line,
  output rtlex_pkg::q_stat_t     stat
);

  rtlex_pkg::grp_t             grp_q  [rtlex_pkg::Q_DEPTH];
  logic [LINE_BITS-1:0]        line_q [rtlex_pkg::Q_DEPTH];
  logic [rtlex_pkg::Q_AW-1:0]  wp, rp;
  logic [rtlex_pkg::Q_AW:0]    fill;

  assign stat.full  = (fill == (rtlex_pkg::Q_AW+1)'(rtlex_pkg::Q_DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_grp     = grp_q[rp];
  assign rd_line    = line_q[rp];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      grp_q[wp]  <= wr_grp;
      line_q[wp] <= wr_line;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= wp + (rtlex_pkg::Q_AW)'(1);
      end
      if (pop) begin
        rp <= rp + (rtlex_pkg::Q_AW)'(1);
      end
      if (push && !pop) begin
        fill <= fill + (rtlex_pkg::Q_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (rtlex_pkg::Q_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rtlex_back.sv -----
// lexer back: hands out the results of each group one transfer at a time
`default_nettype none
module rtlex_back #(
  parameter int LINE_BITS = 24
) (
  input  wire                    clk,
  input  wire                    rst,
  input  rtlex_pkg::grp_t        rd_grp,
  input  wire  [LINE_BITS-1:0]   rd_line,
  input  rtlex_pkg::q_stat_t     stat,
  output logic                   pop,
  output logic                   res_valid,
  input  wire                    res_stall,
  output logic [1:0]             event_res,
  output logic [7:0]             out_byte,
  output logic [1:0]             token_class,
  output logic [23:0]            line_number,
  output logic                   last
);

  logic [1:0]        idx;
  rtlex_pkg::res_t   cur;
  logic              xfer;

  // current record of the group at the queue head
  assign cur         = rd_grp.rec[idx];
  assign res_valid   = !stat.empty;
  assign event_res   = cur.ev;
  assign out_byte    = cur.data;
  assign token_class = cur.cls;
  assign line_number = 24'(rd_line);
  assign last        = ({1'b0, idx} + 3'd1) == rd_grp.cnt;
  assign xfer        = res_valid && !res_stall;
  assign pop         = xfer && last;

  // record index within the group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      if (last) begin
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/resource_text_lexer.sv -----
// top level of the resource text lexer
`default_nettype none
// Streaming lexer for resource text. One byte (or an end-of-input mark) is
// taken per transfer and every cycle when the result queue has room; the
// front resolves the byte in that same cycle and files all of its results
// (zero to four) as one group in a four-group queue. The back hands out one
// result per cycle while res_stall is low, so an item with k results holds
// the output for k transfers, and results are registered in the queue first.
// The item side stalls only while the queue holds four groups; bytes that
// give no result (spaces, comment text, an opening quote) never enter it.
module resource_text_lexer #(
  parameter int LINE_BITS = 24
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          item_valid,
  output logic         item_stall,
  input  wire          action,
  input  wire  [7:0]   data_byte,
  output logic         res_valid,
  input  wire          res_stall,
  output logic [1:0]   event_res,
  output logic [7:0]   out_byte,
  output logic [1:0]   token_class,
  output logic [23:0]  line_number,
  output logic         last
);

  rtlex_pkg::q_stat_t    stat;
  rtlex_pkg::grp_t       wr_grp, rd_grp;
  logic [LINE_BITS-1:0]  wr_line, rd_line;
  logic                  push, pop;

  rtlex_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .data_byte  (data_byte),
    .stat       (stat),
    .push       (push),
    .wr_grp     (wr_grp),
    .wr_line    (wr_line)
  );

  rtlex_fifo #(.LINE_BITS(LINE_BITS)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_grp  (wr_grp),
    .wr_line (wr_line),
    .pop     (pop),
    .rd_grp  (rd_grp),
    .rd_line (rd_line),
    .stat    (stat)
  );

  rtlex_back #(.LINE_BITS(LINE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .rd_grp      (rd_grp),
    .rd_line     (rd_line),
    .stat        (stat),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .event_res   (event_res),
    .out_byte    (out_byte),
    .token_class (token_class),
    .line_number (line_number),
    .last        (last)
  );

  // no group is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("result group pushed into full queue");

  // every filed group holds one to four results
  a_grp_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_grp.cnt != 3'd0 && wr_grp.cnt <= 3'd4))
    else $error("result group with bad count");

  // an unterminated string error is the last result of its group, string class, zero byte
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res == rtlex_pkg::EV_ERR) |->
      (last && token_class == rtlex_pkg::CLS_STR && out_byte == 8'd0))
    else $error("malformed error result");

  // a group leaves the queue only on its final transfer
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> (res_valid && !res_stall && last))
    else $error("queue popped before group completed");

endmodule
`default_nettype wire
